// ----- rtl/mp2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants for the 2-D max pooling block: register map, register
// widths and reset values, default sizing.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    // default sizing
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_WINDOW_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y = 3'd7;

    // register field widths
    localparam int SIZE_W   = 11;
    localparam int WIN_W    = 4;
    localparam int MARGIN_W = 3;

    // register reset values
    localparam logic [SIZE_W-1:0]   RST_SIZE   = 11'd1024;
    localparam logic [WIN_W-1:0]    RST_WIN    = 4'd2;
    localparam logic [MARGIN_W-1:0] RST_MARGIN = 3'd0;

    // result coordinate width
    localparam int COORD_W = 11;

    // result queue depth
    localparam int RQ_DEPTH = 4;

endpackage

// ----- rtl/max_pooling_2d.sv -----
// ----------------------------------------------------------------------------
// max_pooling_2d
// Streaming 2-D max pooling with stride and padding. Partial maxima live in
// a window store RAM indexed by output row (low bits) and output column.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_sample
//  out       output     o_out_valid / i_out_stall  o_pooled, o_col_out,
//                                                  o_row_out, o_run_end,
//                                                  o_plane_end
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// A pixel makes one read-modify-write pass over the window store per
// pooling window that covers it, or holds the sequencer once if none does.
// Non-overlapping windows run at one pixel per cycle while the result queue
// has room. Each result is registered at the store read, then queued.
// Reset is synchronous; the store needs no clearing pass.
// Output stall backs up through a 4-entry result queue into o_in_stall.
// ----------------------------------------------------------------------------
module max_pooling_2d
    import mp2d_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_pooled,
    output logic [COORD_W-1:0]            o_col_out,
    output logic [COORD_W-1:0]            o_row_out,
    output logic                          o_run_end,
    output logic                          o_plane_end
);

    localparam int PB  = $clog2(MAX_WIDTH);
    localparam int OB  = $clog2(MAX_WIDTH + 1);
    localparam int RB  = $clog2(MAX_WINDOW);
    localparam int AB  = RB + OB;
    localparam int EB0 = $clog2(MAX_WIDTH + 4 * MAX_WINDOW) + 1;
    localparam int EB  = (EB0 > SIZE_W + 1) ? EB0 : SIZE_W + 1;
    localparam int QB  = $clog2(RQ_DEPTH);

    // configuration registers
    logic [SIZE_W-1:0]   r_img_w, r_img_h;
    logic [WIN_W-1:0]    r_win_w, r_win_h, r_step_x, r_step_y;
    logic [MARGIN_W-1:0] r_mar_x, r_mar_y;

    // effective (clamped) configuration
    logic [EB-1:0] e_w, e_h, e_kw, e_kh, e_sw, e_sh, e_pw, e_ph;
    logic [EB-1:0] lim_x, lim_y, ce0, re0;

    // position trackers
    logic [PB-1:0] r_col, r_row;
    logic [OB-1:0] r_xlo, r_ylo;
    logic [EB-1:0] r_ce, r_re;
    logic [EB-1:0] pc, pr, ce_c, re_c;
    logic [OB-1:0] xlo_c, ylo_c;
    logic          c_last, r_last, in_acc;

    // sequencer
    logic                   r_sv;
    logic [SAMPLE_BITS-1:0] r_s_smp;
    logic [EB-1:0]          r_s_c, r_s_r, r_s_ce0, r_s_ce, r_s_re;
    logic                   r_s_clast, r_s_rlast;
    logic [OB-1:0]          r_s_xlo, r_s_ox, r_s_oy;
    logic col_ok, row_ok, ncol_ok, nrow_ok, op_ok, credit, issue, last_op, finish;
    logic first_x, first_y, close_x, close_y, run_x, run_y, pend_x, pend_y;

    // read-modify-write stage
    logic                   r_pv, r_p_first, r_p_close, r_p_run, r_p_pend;
    logic [AB-1:0]          r_p_addr;
    logic [SAMPLE_BITS-1:0] r_p_smp;
    logic [OB-1:0]          r_p_ox, r_p_oy;
    logic [SAMPLE_BITS-1:0] rd, old_v, new_v;
    logic                   r_wv;
    logic [AB-1:0]          r_waddr;
    logic [SAMPLE_BITS-1:0] r_wdata;

    // result queue
    logic [SAMPLE_BITS-1:0] r_f_val [RQ_DEPTH];
    logic [COORD_W-1:0]     r_f_ox  [RQ_DEPTH];
    logic [COORD_W-1:0]     r_f_oy  [RQ_DEPTH];
    logic                   r_f_run [RQ_DEPTH];
    logic                   r_f_end [RQ_DEPTH];
    logic [QB-1:0]          r_wp, r_rp;
    logic [QB:0]            r_cnt;
    logic                   push, pop;

    // clamp the registers to their working ranges
    always_comb begin
        e_w  = (r_img_w == '0) ? EB'(1) :
               ((EB'(r_img_w) > EB'(MAX_WIDTH)) ? EB'(MAX_WIDTH) : EB'(r_img_w));
        e_h  = (r_img_h == '0) ? EB'(1) :
               ((EB'(r_img_h) > EB'(MAX_WIDTH)) ? EB'(MAX_WIDTH) : EB'(r_img_h));
        e_kw = (r_win_w == '0) ? EB'(1) :
               ((EB'(r_win_w) > EB'(MAX_WINDOW)) ? EB'(MAX_WINDOW) : EB'(r_win_w));
        e_kh = (r_win_h == '0) ? EB'(1) :
               ((EB'(r_win_h) > EB'(MAX_WINDOW)) ? EB'(MAX_WINDOW) : EB'(r_win_h));
        e_sw = (r_step_x == '0) ? EB'(1) :
               ((EB'(r_step_x) > EB'(MAX_WINDOW)) ? EB'(MAX_WINDOW) : EB'(r_step_x));
        e_sh = (r_step_y == '0) ? EB'(1) :
               ((EB'(r_step_y) > EB'(MAX_WINDOW)) ? EB'(MAX_WINDOW) : EB'(r_step_y));
        e_pw = (EB'(r_mar_x) > (e_kw >> 1)) ? (e_kw >> 1) : EB'(r_mar_x);
        e_ph = (EB'(r_mar_y) > (e_kh >> 1)) ? (e_kh >> 1) : EB'(r_mar_y);
        lim_x = e_w - EB'(1) + e_pw;
        lim_y = e_h - EB'(1) + e_ph;
        ce0   = e_kw - EB'(1) - e_pw;
        re0   = e_kh - EB'(1) - e_ph;
    end

    // first covering window and its end for the incoming pixel
    always_comb begin
        pc     = EB'(r_col);
        pr     = EB'(r_row);
        xlo_c  = (r_col == '0) ? '0 : r_xlo;
        ce_c   = (r_col == '0) ? ce0 : r_ce;
        ylo_c  = (r_row == '0) ? '0 : r_ylo;
        re_c   = (r_row == '0) ? re0 : r_re;
        c_last = (pc == e_w - EB'(1));
        r_last = (pr == e_h - EB'(1));
    end

    // window walk: current and next window checks
    always_comb begin
        col_ok  = (r_s_ce + EB'(1) <= r_s_c + e_kw) && (r_s_ce <= lim_x);
        row_ok  = (r_s_re + EB'(1) <= r_s_r + e_kh) && (r_s_re <= lim_y);
        ncol_ok = (r_s_ce + e_sw + EB'(1) <= r_s_c + e_kw) && (r_s_ce + e_sw <= lim_x);
        nrow_ok = (r_s_re + e_sh + EB'(1) <= r_s_r + e_kh) && (r_s_re + e_sh <= lim_y);
        first_x = (r_s_ce + EB'(1) <= e_kw) ? (r_s_c == '0)
                                            : (r_s_c + e_kw == r_s_ce + EB'(1));
        first_y = (r_s_re + EB'(1) <= e_kh) ? (r_s_r == '0)
                                            : (r_s_r + e_kh == r_s_re + EB'(1));
        close_x = (r_s_ce == r_s_c) || r_s_clast;
        close_y = (r_s_re == r_s_r) || r_s_rlast;
        run_x   = !r_s_clast || !ncol_ok;
        run_y   = !r_s_rlast || !nrow_ok;
        pend_x  = (r_s_ce + e_sw > lim_x);
        pend_y  = (r_s_re + e_sh > lim_y);
        op_ok   = col_ok && row_ok;
        credit  = (r_cnt + (QB+1)'(r_pv)) < (QB+1)'(RQ_DEPTH);
        issue   = r_sv && op_ok && credit;
        last_op = !ncol_ok && !nrow_ok;
        finish  = r_sv && (!op_ok || (credit && last_op));
    end

    assign o_in_stall = r_sv && !finish;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= RST_SIZE;
            r_img_h  <= RST_SIZE;
            r_win_w  <= RST_WIN;
            r_win_h  <= RST_WIN;
            r_step_x <= RST_WIN;
            r_step_y <= RST_WIN;
            r_mar_x  <= RST_MARGIN;
            r_mar_y  <= RST_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_W:  r_img_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_H:  r_img_h  <= i_cfg_data[SIZE_W-1:0];
                CFG_WIN_W:    r_win_w  <= i_cfg_data[WIN_W-1:0];
                CFG_WIN_H:    r_win_h  <= i_cfg_data[WIN_W-1:0];
                CFG_STEP_X:   r_step_x <= i_cfg_data[WIN_W-1:0];
                CFG_STEP_Y:   r_step_y <= i_cfg_data[WIN_W-1:0];
                CFG_MARGIN_X: r_mar_x  <= i_cfg_data[MARGIN_W-1:0];
                CFG_MARGIN_Y: r_mar_y  <= i_cfg_data[MARGIN_W-1:0];
                default:      r_img_w  <= r_img_w;
            endcase
        end
    end

    // raster position and covering-window trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (c_last) begin
                r_col <= '0;
                if (r_last) begin
                    r_row <= '0;
                end else begin
                    r_row <= PB'(pr + EB'(1));
                    if (re_c < pr + EB'(1)) begin
                        r_ylo <= ylo_c + OB'(1);
                        r_re  <= re_c + e_sh;
                    end else begin
                        r_ylo <= ylo_c;
                        r_re  <= re_c;
                    end
                end
            end else begin
                r_col <= PB'(pc + EB'(1));
                if (ce_c < pc + EB'(1)) begin
                    r_xlo <= xlo_c + OB'(1);
                    r_ce  <= ce_c + e_sw;
                end else begin
                    r_xlo <= xlo_c;
                    r_ce  <= ce_c;
                end
            end
        end
    end

    // sequencer: walk covering windows row by row, column by column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (in_acc) begin
            r_sv      <= 1'b1;
            r_s_smp   <= i_sample;
            r_s_c     <= pc;
            r_s_r     <= pr;
            r_s_clast <= c_last;
            r_s_rlast <= r_last;
            r_s_xlo   <= xlo_c;
            r_s_ce0   <= ce_c;
            r_s_ox    <= xlo_c;
            r_s_ce    <= ce_c;
            r_s_oy    <= ylo_c;
            r_s_re    <= re_c;
        end else if (finish) begin
            r_sv <= 1'b0;
        end else if (issue) begin
            if (ncol_ok) begin
                r_s_ox <= r_s_ox + OB'(1);
                r_s_ce <= r_s_ce + e_sw;
            end else begin
                r_s_oy <= r_s_oy + OB'(1);
                r_s_re <= r_s_re + e_sh;
                r_s_ox <= r_s_xlo;
                r_s_ce <= r_s_ce0;
            end
        end
    end

    // issued request: store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= issue;
        end
        r_p_addr  <= {r_s_oy[RB-1:0], r_s_ox};
        r_p_smp   <= r_s_smp;
        r_p_first <= first_x && first_y;
        r_p_close <= close_x && close_y;
        r_p_run   <= close_x && close_y && run_x && run_y;
        r_p_pend  <= pend_x && pend_y;
        r_p_ox    <= r_s_ox;
        r_p_oy    <= r_s_oy;
    end

    mp2d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (2 ** AB)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_pv),
        .i_waddr (r_p_addr),
        .i_wdata (new_v),
        .i_raddr ({r_s_oy[RB-1:0], r_s_ox}),
        .o_rdata (rd)
    );

    // update the partial max, forwarding the previous cycle's write
    always_comb begin
        old_v = (r_wv && (r_waddr == r_p_addr)) ? r_wdata : rd;
        if (r_p_first) begin
            new_v = r_p_smp;
        end else if ($signed(r_p_smp) > $signed(old_v)) begin
            new_v = r_p_smp;
        end else begin
            new_v = old_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else begin
            r_wv <= r_pv;
        end
        r_waddr <= r_p_addr;
        r_wdata <= new_v;
    end

    // result queue
    assign push = r_pv && r_p_close;
    assign pop  = (r_cnt != '0) && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QB'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QB'(1);
            end
            r_cnt <= r_cnt + (QB+1)'(push) - (QB+1)'(pop);
        end
        if (push) begin
            r_f_val[r_wp] <= new_v;
            r_f_ox[r_wp]  <= COORD_W'(r_p_ox);
            r_f_oy[r_wp]  <= COORD_W'(r_p_oy);
            r_f_run[r_wp] <= r_p_run;
            r_f_end[r_wp] <= r_p_pend;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_pooled    = r_f_val[r_rp];
    assign o_col_out   = r_f_ox[r_rp];
    assign o_row_out   = r_f_oy[r_rp];
    assign o_run_end   = r_f_run[r_rp];
    assign o_plane_end = r_f_end[r_rp];

endmodule

// ----- rtl/mp2d_ram.sv -----
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- verif/mp2d_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mp2d_checker
// Watches the config port and both channels of max_pooling_2d, predicts the
// pooled results of each accepted pixel and compares them in order.
// ----------------------------------------------------------------------------
module mp2d_checker
    import mp2d_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic signed [15:0]     i_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic signed [15:0]     i_pooled,
    input  logic [COORD_W-1:0]     i_col_out,
    input  logic [COORD_W-1:0]     i_row_out,
    input  logic                   i_run_end,
    input  logic                   i_plane_end,
    output int                     o_fail_cnt,
    output int                     o_pending,
    output int                     o_result_cnt
);

    typedef struct packed {
        logic signed [15:0] pooled;
        logic [10:0]        col;
        logic [10:0]        row;
        logic               run_end;
        logic               plane_end;
    } t_pool_res;

    t_pool_res   pool_q[$];
    logic [10:0] regs[8];
    int          cur_col, cur_row;
    logic signed [15:0] partial_max[8][1025];

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int n_out(int sz, int win, int pad, int stp);
        int span;
        span = sz + 2 * pad - win;
        return span < 0 ? 0 : span / stp + 1;
    endfunction

    function automatic int first_win(int pos, int win, int pad, int stp);
        int t;
        t = pos + pad - win + 1;
        return t <= 0 ? 0 : (t + stp - 1) / stp;
    endfunction

    // update partial maxima for one pixel and queue finished windows
    task automatic pool_pixel(logic signed [15:0] s);
        int w, h, kw, kh, sw, sh, pw, ph, ow, oh;
        int ylo, yhi, xlo, xhi, r0, c0, n, last;
        t_pool_res res;
        w  = clip(int'(regs[0]), 1, 1024);
        h  = clip(int'(regs[1]), 1, 1024);
        kw = clip(int'(regs[2]), 1, 8);
        kh = clip(int'(regs[3]), 1, 8);
        sw = clip(int'(regs[4]), 1, 8);
        sh = clip(int'(regs[5]), 1, 8);
        pw = int'(regs[6]) < kw / 2 ? int'(regs[6]) : kw / 2;
        ph = int'(regs[7]) < kh / 2 ? int'(regs[7]) : kh / 2;
        ow = n_out(w, kw, pw, sw);
        oh = n_out(h, kh, ph, sh);
        n  = 0;
        if (cur_col >= w || cur_row >= h) begin
            cur_col = 0;
            cur_row = 0;
        end
        if (ow > 0 && oh > 0) begin
            ylo = first_win(cur_row, kh, ph, sh);
            yhi = (cur_row + ph) / sh;
            if (yhi > oh - 1) yhi = oh - 1;
            xlo = first_win(cur_col, kw, pw, sw);
            xhi = (cur_col + pw) / sw;
            if (xhi > ow - 1) xhi = ow - 1;
            for (int oy = ylo; oy <= yhi; oy++) begin
                r0 = oy * sh - ph;
                for (int ox = xlo; ox <= xhi; ox++) begin
                    c0 = ox * sw - pw;
                    if (cur_row == (r0 > 0 ? r0 : 0) && cur_col == (c0 > 0 ? c0 : 0))
                        partial_max[oy % 8][ox] = s;
                    else if (s > partial_max[oy % 8][ox])
                        partial_max[oy % 8][ox] = s;
                    last = (r0 + kh - 1 < h - 1 ? r0 + kh - 1 : h - 1);
                    if (cur_row == last
                        && cur_col == (c0 + kw - 1 < w - 1 ? c0 + kw - 1 : w - 1)) begin
                        res.pooled    = partial_max[oy % 8][ox];
                        res.col       = 11'(ox);
                        res.row       = 11'(oy);
                        res.run_end   = 1'b0;
                        res.plane_end = (ox == ow - 1 && oy == oh - 1) ? 1'b1 : 1'b0;
                        pool_q.push_back(res);
                        n++;
                    end
                end
            end
            if (n > 0) pool_q[pool_q.size() - 1].run_end = 1'b1;
        end
        if (cur_col + 1 < w) begin
            cur_col++;
        end else begin
            cur_col = 0;
            cur_row = (cur_row + 1 < h) ? cur_row + 1 : 0;
        end
    endtask

    // compare one delivered result against the oldest expectation
    task automatic check_result();
        t_pool_res e;
        if (pool_q.size() == 0) begin
            $error("unexpected result pooled=%0d col=%0d row=%0d",
                   i_pooled, i_col_out, i_row_out);
            o_fail_cnt++;
            return;
        end
        e = pool_q.pop_front();
        if (i_pooled !== e.pooled) begin
            $error("pooled: expected %0d, got %0d", e.pooled, i_pooled);
            o_fail_cnt++;
        end
        if (i_col_out !== e.col) begin
            $error("col_out: expected %0d, got %0d", e.col, i_col_out);
            o_fail_cnt++;
        end
        if (i_row_out !== e.row) begin
            $error("row_out: expected %0d, got %0d", e.row, i_row_out);
            o_fail_cnt++;
        end
        if (i_run_end !== e.run_end) begin
            $error("run_end: expected %0d, got %0d", e.run_end, i_run_end);
            o_fail_cnt++;
        end
        if (i_plane_end !== e.plane_end) begin
            $error("plane_end: expected %0d, got %0d", e.plane_end, i_plane_end);
            o_fail_cnt++;
        end
    endtask

    // counters are two-state and start at zero
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs    = '{11'd1024, 11'd1024, 11'd2, 11'd2, 11'd2, 11'd2, 11'd0, 11'd0};
            cur_col = 0;
            cur_row = 0;
            pool_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
                o_result_cnt++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_W, CFG_IMAGE_H: regs[i_cfg_index] = i_cfg_data;
                    CFG_MARGIN_X, CFG_MARGIN_Y:
                        regs[i_cfg_index] = {8'd0, i_cfg_data[2:0]};
                    default: regs[i_cfg_index] = {7'd0, i_cfg_data[3:0]};
                endcase
                cur_col = 0;
                cur_row = 0;
            end
            if (i_in_valid && !i_in_stall) pool_pixel(i_sample);
        end
        o_pending = pool_q.size();
    end

endmodule

// ----- verif/tb_max_pooling_2d.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_pooling_2d
// Drives pixel planes under several pooling setups with random gaps and
// output stalls; mp2d_checker predicts and checks every pooled result.
// ----------------------------------------------------------------------------
module tb_max_pooling_2d;
    import mp2d_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [15:0]    sample;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    pooled;
    logic [COORD_W-1:0]    col_out, row_out;
    logic                  run_end, plane_end;
    int                    fail_cnt, pending, result_cnt;
    int                    pixel_cnt;
    bit                    hold_out;

    max_pooling_2d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_sample(sample),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_pooled(pooled),
        .o_col_out(col_out), .o_row_out(row_out), .o_run_end(run_end),
        .o_plane_end(plane_end)
    );

    mp2d_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_sample(sample),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_pooled(pooled),
        .i_col_out(col_out), .i_row_out(row_out), .i_run_end(run_end),
        .i_plane_end(plane_end),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_result_cnt(result_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    endfunction

    // receiver stall: random, with repeated long hold-offs while requested
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup(int w, int h, int kw, int kh, int sx, int sy, int mx, int my);
        write_reg(CFG_IMAGE_W, w);
        write_reg(CFG_IMAGE_H, h);
        write_reg(CFG_WIN_W, kw);
        write_reg(CFG_WIN_H, kh);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_MARGIN_X, mx);
        write_reg(CFG_MARGIN_Y, my);
    endtask

    // one pixel request, held until accepted
    task automatic send_pixel(logic signed [15:0] v, bit no_gap);
        int g;
        if (!no_gap) begin
            g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (g > 0) begin
                in_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pixel_cnt++;
    endtask

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        int t;
        in_valid <= 1'b0;
        @(posedge i_clk);
        t = 0;
        while (pending != 0 && t < 20000) begin
            @(posedge i_clk);
            t++;
        end
        // a pixel closing no window may still be in flight
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_plane(int n, bit no_gap);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(), no_gap);
        drain();
    endtask

    initial begin
        int w, h;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        pixel_cnt = 0;
        hold_out  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme samples, overlapping windows with padding
        setup(4, 4, 3, 3, 1, 1, 4, 4);
        send_pixel(16'sh8000, 1'b1);
        send_pixel(16'sh7fff, 1'b1);
        send_pixel(16'sh0000, 1'b0);
        send_pixel(16'shffff, 1'b0);
        for (int i = 0; i < 12; i++) send_pixel(16'sh0001 << i, 1'b0);
        drain();
        // window larger than image still gives one padded result; out-of-range registers saturate
        setup(2, 2, 15, 15, 15, 15, 7, 7);
        run_plane(5, 1'b0);
        // large image extremes
        setup(2047, 1, 8, 1, 8, 1, 0, 0);
        run_plane(5, 1'b0);
        setup(0, 0, 0, 0, 0, 0, 0, 0);
        run_plane(3, 1'b0);

        // back-pressure: stride 1 full window bursts while output is held off
        setup(6, 6, 8, 8, 1, 1, 4, 4);
        hold_out = 1'b1;
        for (int i = 0; i < 36; i++) send_pixel(rand_pixel(), 1'b1);
        hold_out = 1'b0;
        drain();

        // random setups, one or two planes each
        while (pixel_cnt < 320) begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 7);
            setup(w, h, $urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(0, 4), $urandom_range(0, 4));
            run_plane(w * h * $urandom_range(1, 2), $urandom_range(0, 4) == 0);
        end

        $display("Pixels sent: %0d, pooled results checked: %0d", pixel_cnt, result_cnt);
        $display("Covered padding, strides, saturated registers, empty output, backpressure.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mp2d_pkg.sv
rtl/mp2d_ram.sv
rtl/max_pooling_2d.sv
verif/mp2d_checker.sv
verif/tb_max_pooling_2d.sv
